@@ design/cdt_pkg.sv @@
`default_nettype none

package cdt_pkg;

  localparam int NUM_GROUPS = 5;
  localparam int NUM_DET    = 8;
  localparam int NUM_SEG    = 89;
  localparam int SEG_MAX    = 18;
  localparam int HIT_W      = 256;
  localparam int WORD_W     = 64;
  localparam int THR_W      = 9;
  localparam int WIDTH_W    = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;

  // detector order: TOF1x, TOF1y, AC1, AC2, AC3, TOF2x, WC1, WC2
  localparam int DET_TOF1X = 0;
  localparam int DET_TOF1Y = 1;
  localparam int DET_AC1   = 2;
  localparam int DET_AC2   = 3;
  localparam int DET_AC3   = 4;
  localparam int DET_TOF2X = 5;
  localparam int DET_WC1   = 6;
  localparam int DET_WC2   = 7;

  localparam int DET_BASE  [NUM_DET] = '{0, 34, 52, 66, 80, 94, 130, 154};
  localparam int DET_COUNT [NUM_DET] = '{17, 9, 7, 7, 7, 18, 12, 12};
  localparam int DET_FIRST [NUM_DET] = '{0, 17, 26, 33, 40, 47, 65, 77};

  // inclusive segment ranges per detector and group, TOF1y row unused
  localparam int GRP_LO [NUM_DET][NUM_GROUPS] = '{
    '{0, 4, 7, 10, 13},
    '{0, 0, 0, 0, 0},
    '{0, 0, 0, 1, 1},
    '{0, 0, 0, 1, 1},
    '{0, 0, 0, 1, 1},
    '{0, 3, 6, 9, 12},
    '{0, 1, 3, 4, 5},
    '{0, 1, 3, 5, 6}
  };
  localparam int GRP_HI [NUM_DET][NUM_GROUPS] = '{
    '{3, 6, 9, 12, 16},
    '{0, 0, 0, 0, 0},
    '{5, 5, 6, 6, 6},
    '{5, 5, 6, 6, 6},
    '{5, 5, 6, 6, 6},
    '{5, 8, 11, 14, 17},
    '{4, 8, 10, 11, 11},
    '{6, 9, 11, 11, 11}
  };

  typedef enum logic {
    REG_STRETCH_WIDTHS = 1'b0,
    REG_MULT_THRESHOLD = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] widths;
    logic [THR_W-1:0]      thr;
  } cfg_t;

  typedef logic [NUM_SEG-1:0] seg_vec_t;

  // all segments of one detector
  function automatic seg_vec_t det_mask(int d);
    seg_vec_t m;
    m = '0;
    for (int i = 0; i < SEG_MAX; i++) begin
      if (i < DET_COUNT[d]) m[DET_FIRST[d] + i] = 1'b1;
    end
    return m;
  endfunction

  // segments of detector d that belong to group k
  function automatic seg_vec_t grp_mask(int d, int k);
    seg_vec_t m;
    m = '0;
    for (int i = 0; i < SEG_MAX; i++) begin
      if (i >= GRP_LO[d][k] && i <= GRP_HI[d][k] && i < DET_COUNT[d]) begin
        m[DET_FIRST[d] + i] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ design/cdt_if.sv @@
`default_nettype none

interface cdt_in_if
  import cdt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] hits_word0;
  logic [WORD_W-1:0] hits_word1;
  logic [WORD_W-1:0] hits_word2;
  logic [WORD_W-1:0] hits_word3;

  modport source (
    output valid, hits_word0, hits_word1, hits_word2, hits_word3,
    input  ready
  );
  modport sink (
    input  valid, hits_word0, hits_word1, hits_word2, hits_word3,
    output ready
  );
endinterface

interface cdt_out_if
  import cdt_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  multiplicity_trigger;
  logic                  any_hit_trigger;
  logic [NUM_GROUPS-1:0] group_triggers;
  logic                  combined_trigger;

  modport source (
    output valid, multiplicity_trigger, any_hit_trigger, group_triggers,
           combined_trigger,
    input  ready
  );
  modport sink (
    input  valid, multiplicity_trigger, any_hit_trigger, group_triggers,
           combined_trigger,
    output ready
  );
endinterface

`default_nettype wire

@@ design/detector_coincidence_trigger.sv @@
`default_nettype none

// coincidence trigger over 256 hit channels, one 4 ns sample per item. the
// block takes one item every clock cycle unless the pipe is full and the
// output side is stalled, and returns exactly one result per item; an
// accepted item passes through the four-stage pipeline (input register,
// segment and partial-count register, group and sub-count register, result
// register), each stage advancing on its own so that a held result does
// not block items behind it until the pipe is full.
// channel pairs 0..177 form 89 detector segments; each segment has an 8-bit
// pulse-stretch counter that is reloaded with its detector's width (byte k
// of stretch_widths) on a hit and counts down otherwise, and the counters
// carry over from one item to the next, stepping as an item leaves the
// input register. stretched segments are ORed over fixed group ranges and
// combined into five group triggers. the multiplicity trigger compares the
// count of hit channels below NUM_CHANNELS with multiplicity_threshold (a
// threshold of zero always fires, above NUM_CHANNELS never). registers sit
// at byte address 0 (stretch_widths) and 8 (multiplicity_threshold) and are
// only to be written while no item is in flight.
module detector_coincidence_trigger
  import cdt_pkg::*;
#(
  parameter int NUM_CHANNELS = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  cdt_in_if.sink                in_i,
  cdt_out_if.source             out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int N8   = HIT_W / 8;   // 8-bit chunks
  localparam int C8W  = 4;           // count of one chunk, 0..8
  localparam int NSUB = N8 / 8;      // sub-counts of eight chunks
  localparam int C64W = 7;           // count of 64 channels, 0..64

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  cfg_t cfg;

  cdt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------------
  // stage handshake: each stage loads when it is empty or drains
  // ---------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic s1_free, s2_free, s3_free, out_free;
  logic in_acc, adv2, adv3, adv4;

  assign out_free = !out_v_q || out_o.ready;
  assign s3_free  = !s3_v_q || out_free;
  assign s2_free  = !s2_v_q || s3_free;
  assign s1_free  = !s1_v_q || s2_free;

  assign in_i.ready = s1_free;
  assign in_acc     = in_i.valid & s1_free;
  assign adv2       = s1_v_q & s2_free;
  assign adv3       = s2_v_q & s3_free;
  assign adv4       = s3_v_q & out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_free)  s1_v_q  <= in_i.valid;
      if (s2_free)  s2_v_q  <= s1_v_q;
      if (s3_free)  s3_v_q  <= s2_v_q;
      if (out_free) out_v_q <= s3_v_q;
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: input register
  // ---------------------------------------------------------------------
  logic [HIT_W-1:0] hits_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hits_q <= {in_i.hits_word3, in_i.hits_word2, in_i.hits_word1, in_i.hits_word0};
    end
  end

  // channels at or above NUM_CHANNELS do not count
  logic [HIT_W-1:0] chan_mask;
  logic [HIT_W-1:0] hits_m;

  for (genvar i = 0; i < HIT_W; i++) begin : g_mask
    assign chan_mask[i] = (i < NUM_CHANNELS);
  end
  assign hits_m = hits_q & chan_mask;

  // ---------------------------------------------------------------------
  // stage 2: stretched segments, per-chunk counts, any hit
  // ---------------------------------------------------------------------
  seg_vec_t       seg_d, seg_q;
  logic [C8W-1:0] cnt8_d [N8];
  logic [C8W-1:0] cnt8_q [N8];
  logic           any2_q;

  cdt_stretch u_stretch (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .hits_i   (hits_q),
    .widths_i (cfg.widths),
    .step_i   (adv2),
    .seg_o    (seg_d)
  );

  always_comb begin
    for (int c = 0; c < N8; c++) begin
      cnt8_d[c] = '0;
      for (int b = 0; b < 8; b++) begin
        cnt8_d[c] = cnt8_d[c] + C8W'(hits_m[8*c + b]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      seg_q  <= seg_d;
      cnt8_q <= cnt8_d;
      any2_q <= |hits_m;
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: group coincidences, counts per 64 channels
  // ---------------------------------------------------------------------
  logic [NUM_GROUPS-1:0] grp_d, grp3_q;
  logic [C64W-1:0]       cnt64_d [NSUB];
  logic [C64W-1:0]       cnt64_q [NSUB];
  logic                  any3_q;

  cdt_coinc u_coinc (
    .seg_i (seg_q),
    .grp_o (grp_d)
  );

  always_comb begin
    for (int s = 0; s < NSUB; s++) begin
      cnt64_d[s] = '0;
      for (int c = 0; c < 8; c++) begin
        cnt64_d[s] = cnt64_d[s] + C64W'(cnt8_q[8*s + c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      grp3_q  <= grp_d;
      cnt64_q <= cnt64_d;
      any3_q  <= any2_q;
    end
  end

  // ---------------------------------------------------------------------
  // stage 4: total count, threshold compare, result register
  // ---------------------------------------------------------------------
  logic [THR_W-1:0] total;

  always_comb begin
    total = '0;
    for (int s = 0; s < NSUB; s++) begin
      total = total + THR_W'(cnt64_q[s]);
    end
  end

  logic                  mult_q, any_q, comb_q;
  logic [NUM_GROUPS-1:0] grp_q;

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      mult_q <= (total >= cfg.thr);
      any_q  <= any3_q;
      grp_q  <= grp3_q;
      comb_q <= |grp3_q;
    end
  end

  assign out_o.valid                = out_v_q;
  assign out_o.multiplicity_trigger = mult_q;
  assign out_o.any_hit_trigger      = any_q;
  assign out_o.group_triggers       = grp_q;
  assign out_o.combined_trigger     = comb_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // combined bit follows the group bits of the same item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (comb_q == (grp_q != '0)))
    else $error("combined trigger does not match group bits");

  // with no channel hit only a zero threshold fires
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !any_q) |-> (mult_q == (cfg.thr == '0)))
    else $error("multiplicity trigger without hits");

  // a threshold above the channel count can never be reached
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (cfg.thr > THR_W'(NUM_CHANNELS))) |-> !mult_q)
    else $error("multiplicity trigger above channel count");

endmodule

`default_nettype wire

@@ design/cdt_cfg.sv @@
`default_nettype none

module cdt_cfg
  import cdt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  // 8-byte register slots, byte offset bits ignored
  assign idx    = reg_idx_e'(paddr[CFG_ADDR_W-1]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_STRETCH_WIDTHS: cfg_q.widths <= pwdata;
        REG_MULT_THRESHOLD: cfg_q.thr    <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_STRETCH_WIDTHS: prdata = cfg_q.widths;
      REG_MULT_THRESHOLD: prdata = {{(CFG_DATA_W-THR_W){1'b0}}, cfg_q.thr};
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ design/cdt_stretch.sv @@
`default_nettype none

module cdt_stretch
  import cdt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [HIT_W-1:0]      hits_i,
  input  logic [CFG_DATA_W-1:0] widths_i,
  input  logic                  step_i,
  output seg_vec_t              seg_o
);

  for (genvar d = 0; d < NUM_DET; d++) begin : g_det
    for (genvar n = 0; n < SEG_MAX; n++) begin : g_n
      if (n < DET_COUNT[d]) begin : g_seg
        localparam int Seg = DET_FIRST[d] + n;
        localparam int Ch  = DET_BASE[d] + 2 * n;

        logic               hit;
        logic [WIDTH_W-1:0] ctr_q;
        logic [WIDTH_W-1:0] ctr_d;

        assign hit = hits_i[Ch] & hits_i[Ch+1];

        // reload on a hit, otherwise count down to zero
        always_comb begin
          ctr_d = ctr_q;
          if (hit) begin
            ctr_d = widths_i[WIDTH_W*d +: WIDTH_W];
          end else if (ctr_q != '0) begin
            ctr_d = ctr_q - WIDTH_W'(1);
          end
        end

        always_ff @(posedge clk_i or negedge rst_ni) begin
          if (!rst_ni) begin
            ctr_q <= '0;
          end else if (step_i) begin
            ctr_q <= ctr_d;
          end
        end

        assign seg_o[Seg] = hit | (ctr_q != '0);
      end
    end
  end

endmodule

`default_nettype wire

@@ design/cdt_coinc.sv @@
`default_nettype none

module cdt_coinc
  import cdt_pkg::*;
(
  input  seg_vec_t              seg_i,
  output logic [NUM_GROUPS-1:0] grp_o
);

  logic tof1y_any;

  assign tof1y_any = |(seg_i & det_mask(DET_TOF1Y));

  for (genvar k = 0; k < NUM_GROUPS; k++) begin : g_grp
    logic [NUM_DET-1:0] g;
    logic               ac;

    for (genvar d = 0; d < NUM_DET; d++) begin : g_d
      if (d == DET_TOF1Y) begin : g_any
        assign g[d] = tof1y_any;
      end else begin : g_rng
        assign g[d] = |(seg_i & grp_mask(d, k));
      end
    end

    // two of three aerogel counters
    assign ac = (g[DET_AC1] & g[DET_AC2]) | (g[DET_AC1] & g[DET_AC3])
              | (g[DET_AC2] & g[DET_AC3]);

    assign grp_o[k] = g[DET_TOF1X] & g[DET_TOF2X] & g[DET_TOF1Y] & ac
                    & g[DET_WC1] & g[DET_WC2];
  end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none

module testbench;
  import cdt_pkg::*;

  // run length guard, far above the slowest correct run (about 1.6k items,
  // each with a worst-case input gap and output stall)
  localparam int CYCLE_LIMIT = 600_000;

  // segment layout: first channel, segment count and counter offset per detector
  localparam int SEG_BASE [NUM_DET] = '{0, 34, 52, 66, 80, 94, 130, 154};
  localparam int SEG_NUM  [NUM_DET] = '{17, 9, 7, 7, 7, 18, 12, 12};
  localparam int SEG_OFS  [NUM_DET] = '{0, 17, 26, 33, 40, 47, 65, 77};

  // inclusive segment span of each group, per detector (TOF1y row unused)
  localparam int SPAN_LO [NUM_DET][NUM_GROUPS] = '{
    '{0, 4, 7, 10, 13}, '{0, 0, 0, 0, 0},
    '{0, 0, 0, 1, 1}, '{0, 0, 0, 1, 1}, '{0, 0, 0, 1, 1},
    '{0, 3, 6, 9, 12}, '{0, 1, 3, 4, 5}, '{0, 1, 3, 5, 6}
  };
  localparam int SPAN_HI [NUM_DET][NUM_GROUPS] = '{
    '{3, 6, 9, 12, 16}, '{0, 0, 0, 0, 0},
    '{5, 5, 6, 6, 6}, '{5, 5, 6, 6, 6}, '{5, 5, 6, 6, 6},
    '{5, 8, 11, 14, 17}, '{4, 8, 10, 11, 11}, '{6, 9, 11, 11, 11}
  };

  typedef logic [HIT_W-1:0] hit_vec_t;

  // one result item as the block reports it
  typedef struct packed {
    logic                  mult;
    logic                  any;
    logic [NUM_GROUPS-1:0] grp;
    logic                  comb;
  } trig_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_SETUP
  } row_kind_e;

  // one row of the directed stimulus: either a hit sample or new settings
  typedef struct {
    row_kind_e             kind;
    hit_vec_t              hits;
    logic                  typed;
    trig_t                 want;
    logic [CFG_DATA_W-1:0] widths;
    logic [THR_W-1:0]      thr;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  cdt_in_if  hits_if ();
  cdt_out_if trig_if ();

  detector_coincidence_trigger u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (hits_if),
    .out_o   (trig_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the block's state: settings and the per-segment stretch counters
  logic [CFG_DATA_W-1:0] widths_shadow = '0;
  logic [THR_W-1:0]      thr_shadow = '0;
  logic [WIDTH_W-1:0]    stretch_ctr [NUM_SEG] = '{default: '0};

  trig_t     pending_triggers [$];
  stim_row_t directed_rows [$];
  trig_t     due;
  int        errors = 0;
  int        src_calm = 0;
  int        sink_hold = 0;
  int        sink_calm = 0;

  // 12 time unit clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // reset held low at the start only, then released for the rest of the run
  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // gap length: mostly short, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // the two channels that make up segment n of detector d
  function automatic hit_vec_t pair_hit(int d, int n);
    hit_vec_t h;
    h = '0;
    h[SEG_BASE[d] + 2 * n]     = 1'b1;
    h[SEG_BASE[d] + 2 * n + 1] = 1'b1;
    return h;
  endfunction

  // advance the stretch counters by one sample and work out its triggers
  function automatic trig_t predict_triggers(hit_vec_t h);
    trig_t            r;
    logic [SEG_MAX-1:0] lit [NUM_DET];
    logic [WIDTH_W-1:0] w;
    logic [NUM_DET-1:0] g;
    logic             ac_ok;
    int               idx;
    r.mult = ($countones(h) >= int'(thr_shadow));
    r.any  = |h;
    for (int d = 0; d < NUM_DET; d++) begin
      w = widths_shadow[WIDTH_W * d +: WIDTH_W];
      lit[d] = '0;
      for (int n = 0; n < SEG_NUM[d]; n++) begin
        idx = SEG_OFS[d] + n;
        if (h[SEG_BASE[d] + 2 * n] && h[SEG_BASE[d] + 2 * n + 1]) begin
          // a hit reloads the counter and reads as on
          stretch_ctr[idx] = w;
          lit[d][n] = 1'b1;
        end else if (stretch_ctr[idx] != '0) begin
          // still inside the stretch window
          stretch_ctr[idx] = stretch_ctr[idx] - WIDTH_W'(1);
          lit[d][n] = 1'b1;
        end
      end
    end
    for (int k = 0; k < NUM_GROUPS; k++) begin
      for (int d = 0; d < NUM_DET; d++) begin
        g[d] = 1'b0;
        if (d == DET_TOF1Y) begin
          g[d] = |lit[d];
        end else begin
          for (int n = SPAN_LO[d][k]; n <= SPAN_HI[d][k]; n++) g[d] |= lit[d][n];
        end
      end
      // two of three aerogel counters
      ac_ok = (g[DET_AC1] & g[DET_AC2]) | (g[DET_AC1] & g[DET_AC3]) |
              (g[DET_AC2] & g[DET_AC3]);
      r.grp[k] = g[DET_TOF1X] & g[DET_TOF2X] & g[DET_TOF1Y] & ac_ok &
                 g[DET_WC1] & g[DET_WC2];
    end
    r.comb = |r.grp;
    return r;
  endfunction

  // a minimal coincidence for group k: one segment per detector, the
  // aerogel counters chosen by ac_sel, one detector optionally left out
  function automatic hit_vec_t group_hits(int k, logic [2:0] ac_sel, int skip_det = -1);
    hit_vec_t h;
    h = '0;
    for (int d = 0; d < NUM_DET; d++) begin
      if (d == skip_det) continue;
      if (d >= DET_AC1 && d <= DET_AC3) begin
        if (ac_sel[d - DET_AC1]) h |= pair_hit(d, SPAN_LO[d][k]);
      end else if (d == DET_TOF1Y) begin
        h |= pair_hit(d, SEG_NUM[d] - 1);
      end else begin
        h |= pair_hit(d, SPAN_HI[d][k]);
      end
    end
    return h;
  endfunction

  // random sample: mostly a group-shaped coincidence with random content and
  // noise, the rest dense random words or the all-zero and all-one corners
  function automatic hit_vec_t random_hits();
    hit_vec_t h;
    int       pick;
    int       k;
    int       lo;
    int       hi;
    int       noise;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      for (int i = 0; i < HIT_W / 32; i++) h[32 * i +: 32] = $urandom;
      return h;
    end
    if (pick < 12) return (pick == 10) ? '0 : '1;
    h = '0;
    k = $urandom_range(0, NUM_GROUPS - 1);
    for (int d = 0; d < NUM_DET; d++) begin
      if ($urandom_range(0, 9) < 8) begin
        lo = (d == DET_TOF1Y) ? 0 : SPAN_LO[d][k];
        hi = (d == DET_TOF1Y) ? SEG_NUM[d] - 1 : SPAN_HI[d][k];
        h |= pair_hit(d, $urandom_range(lo, hi));
      end
    end
    // stray single channels, sometimes many to push the multiplicity count
    noise = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4);
    repeat (noise) h[$urandom_range(0, HIT_W - 1)] = 1'b1;
    return h;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_widths();
    logic [CFG_DATA_W-1:0] v;
    for (int b = 0; b < NUM_DET; b++) begin
      case ($urandom_range(0, 5))
        0:       v[WIDTH_W * b +: WIDTH_W] = '0;
        1, 2, 3: v[WIDTH_W * b +: WIDTH_W] = WIDTH_W'($urandom_range(1, 4));
        4:       v[WIDTH_W * b +: WIDTH_W] = WIDTH_W'($urandom_range(0, 255));
        default: v[WIDTH_W * b +: WIDTH_W] = '1;
      endcase
    end
    return v;
  endfunction

  function automatic logic [THR_W-1:0] random_thr();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return THR_W'(256);
      2:       return THR_W'(257);
      3:       return '1;
      4, 5:    return THR_W'($urandom_range(1, 12));
      default: return THR_W'($urandom_range(100, 160));
    endcase
  endfunction

  function automatic void add_item(hit_vec_t h, logic typed = 1'b0, trig_t want = '0);
    stim_row_t row;
    row.kind   = ROW_ITEM;
    row.hits   = h;
    row.typed  = typed;
    row.want   = want;
    row.widths = '0;
    row.thr    = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_setup(logic [CFG_DATA_W-1:0] w, logic [THR_W-1:0] t);
    stim_row_t row;
    row.kind   = ROW_SETUP;
    row.hits   = '0;
    row.typed  = 1'b0;
    row.want   = '0;
    row.widths = w;
    row.thr    = t;
    directed_rows.push_back(row);
  endfunction

  task automatic check_bits(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      if (errors < 10) $display("mismatch %s: expected %0h, got %0h", what, want, got);
      errors++;
    end
  endtask

  // present one sample and hold it until the block takes it; valid stays
  // high so that back-to-back items need no extra edge
  task automatic send_hits(hit_vec_t h, logic typed = 1'b0, trig_t want = '0);
    trig_t predicted;
    hits_if.valid      <= 1'b1;
    hits_if.hits_word0 <= h[0 +: WORD_W];
    hits_if.hits_word1 <= h[WORD_W +: WORD_W];
    hits_if.hits_word2 <= h[2 * WORD_W +: WORD_W];
    hits_if.hits_word3 <= h[3 * WORD_W +: WORD_W];
    do @(posedge clk_i); while (!hits_if.ready);
    // the counters step on every accepted sample, typed rows included
    predicted = predict_triggers(h);
    pending_triggers.push_back(typed ? want : predicted);
  endtask

  // wait until every outstanding result has come back, then let the pipe settle
  task automatic drain_results();
    hits_if.valid <= 1'b0;
    while (pending_triggers.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // random spacing between samples, with calm stretches and the odd full drain
  task automatic pace_input();
    if (src_calm > 0) begin
      src_calm--;
    end else if ($urandom_range(0, 149) == 0) begin
      drain_results();
    end else if ($urandom_range(0, 39) == 0) begin
      src_calm = $urandom_range(20, 120);
    end else if ($urandom_range(0, 2) == 0) begin
      hits_if.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end
  endtask

  // two-phase register write; the write lands on the access edge
  task automatic cfg_write(reg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_STRETCH_WIDTHS) widths_shadow = val;
    else thr_shadow = val[THR_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_readback(reg_idx_e idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_STRETCH_WIDTHS) check_bits("stretch_widths readback", prdata, widths_shadow);
    else check_bits("multiplicity_threshold readback", 64'(prdata[THR_W-1:0]),
                    64'(thr_shadow));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // settings change only with the pipe empty
  task automatic load_settings(logic [CFG_DATA_W-1:0] w, logic [THR_W-1:0] t);
    drain_results();
    cfg_write(REG_STRETCH_WIDTHS, w);
    cfg_readback(REG_STRETCH_WIDTHS);
    cfg_write(REG_MULT_THRESHOLD, {{(CFG_DATA_W - THR_W){1'b0}}, t});
    cfg_readback(REG_MULT_THRESHOLD);
  endtask

  // output side: random stalls, mostly short, with calm stretches
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      trig_if.ready <= 1'b0;
    end else if (sink_hold > 0) begin
      trig_if.ready <= 1'b0;
      sink_hold--;
    end else begin
      trig_if.ready <= 1'b1;
      if (sink_calm > 0) sink_calm--;
      else if ($urandom_range(0, 39) == 0) sink_calm = $urandom_range(20, 120);
      else if ($urandom_range(0, 3) == 0) sink_hold = gap_len();
    end
  end

  // result checker: each accepted result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && trig_if.valid && trig_if.ready) begin
      if (pending_triggers.size() == 0) begin
        if (errors < 10) $display("result item with no sample outstanding");
        errors++;
      end else begin
        due = pending_triggers.pop_front();
        check_bits("multiplicity_trigger", 64'(trig_if.multiplicity_trigger), 64'(due.mult));
        check_bits("any_hit_trigger", 64'(trig_if.any_hit_trigger), 64'(due.any));
        check_bits("group_triggers", 64'(trig_if.group_triggers), 64'(due.grp));
        check_bits("combined_trigger", 64'(trig_if.combined_trigger), 64'(due.comb));
      end
    end
  end

  // watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL detector_coincidence_trigger");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] w;
    // every input known from time zero
    hits_if.valid      <= 1'b0;
    hits_if.hits_word0 <= '0;
    hits_if.hits_word1 <= '0;
    hits_if.hits_word2 <= '0;
    hits_if.hits_word3 <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;

    // directed part, settings after reset (no stretch, threshold zero)
    add_item('0, 1'b1, '{1'b1, 1'b0, 5'h00, 1'b0});
    // every channel: all segments hit, so every group fires
    add_item('1, 1'b1, '{1'b1, 1'b1, 5'h1f, 1'b1});
    // top channel alone, outside every segment
    add_item({1'b1, {(HIT_W - 1){1'b0}}}, 1'b1, '{1'b1, 1'b1, 5'h00, 1'b0});
    // a lone channel is half a pair
    add_item(hit_vec_t'(1), 1'b1, '{1'b1, 1'b1, 5'h00, 1'b0});
    add_item(pair_hit(DET_WC2, SEG_NUM[DET_WC2] - 1));
    // threshold above the channel count never fires
    add_setup('0, THR_W'(257));
    add_item('1, 1'b1, '{1'b0, 1'b1, 5'h1f, 1'b1});
    add_setup('0, '1);
    add_item('1, 1'b1, '{1'b0, 1'b1, 5'h1f, 1'b1});
    // threshold at exactly the channel count
    add_setup('0, THR_W'(256));
    add_item('1, 1'b1, '{1'b1, 1'b1, 5'h1f, 1'b1});
    add_item({1'b0, {(HIT_W - 1){1'b1}}}, 1'b1, '{1'b0, 1'b1, 5'h1f, 1'b1});
    // aerogel majority and a missing water counter, no stretching
    add_setup('0, THR_W'(1));
    add_item(group_hits(2, 3'b001));
    add_item(group_hits(2, 3'b110));
    add_item(group_hits(4, 3'b111));
    add_item(group_hits(0, 3'b011, DET_WC2));
    // longest stretch: segments stay on for many samples after a hit
    add_setup('1, THR_W'(1));
    add_item(group_hits(0, 3'b011));
    add_item('0);
    add_item('0);
    add_item(group_hits(3, 3'b101));
    // short, uneven stretch per detector
    add_setup(64'h0302_0102_0301_0201, THR_W'(2));
    add_item(group_hits(1, 3'b110));
    add_item('0);
    add_item('0);
    add_item('0);

    wait (rst_ni);
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_SETUP) begin
        load_settings(directed_rows[i].widths, directed_rows[i].thr);
      end else begin
        send_hits(directed_rows[i].hits, directed_rows[i].typed, directed_rows[i].want);
        pace_input();
      end
    end

    // random part in phases, new settings between phases
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       w = '0;
        1:       w = '1;
        default: w = random_widths();
      endcase
      load_settings(w, random_thr());
      repeat (200) begin
        send_hits(random_hits());
        pace_input();
      end
    end

    drain_results();
    if (errors == 0) begin
      $display("PASS detector_coincidence_trigger");
    end else begin
      $display("FAIL detector_coincidence_trigger");
    end
    $finish;
  end

endmodule

`default_nettype wire
